### src/maze_wall_and_value_map_unit_defines.svh
// Assertion macros for the maze map unit
`ifndef MAZE_WALL_AND_VALUE_MAP_UNIT_DEFINES_SVH
`define MAZE_WALL_AND_VALUE_MAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MWVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwvm: check failed");
`define MWVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwvm: check failed");
`else
`define MWVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MWVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/mwvm_pkg.sv
`default_nettype none

package mwvm_pkg;

    localparam int MAZE_SIDE_DEF = 16;
    localparam int INF_VALUE_DEF = 255;
    localparam int QUEUE_DEPTH   = 2;   // power of two
    localparam int COORD_W       = 5;
    localparam int VALUE_W       = 8;
    localparam int WALL_SLOTS    = 3;

    typedef enum logic [2:0] {
        CMD_REINIT    = 3'd0,
        CMD_SET_WALL  = 3'd1,
        CMD_DEL_WALL  = 3'd2,
        CMD_QUERY     = 3'd3,
        CMD_WRITE_VAL = 3'd4,
        CMD_READ_VAL  = 3'd5,
        CMD_NEIGHBOR  = 3'd6,
        CMD_SENSE     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef enum logic [2:0] {
        K_INIT,
        K_CONST,
        K_WALL_WR,
        K_WALL_RD,
        K_VAL_WR,
        K_VAL_RD
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic [COORD_W-1:0]          x;
        logic [COORD_W-1:0]          y;
        logic [WALL_SLOTS-1:0]       mask;
        t_dir [WALL_SLOTS-1:0]       dir;
        logic                        wall_val;
        logic [VALUE_W-1:0]          data;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALL,
        BK_READ
    } t_bk_state;

endpackage

`default_nettype wire

### src/mwvm_if.sv
`default_nettype none

interface mwvm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [1:0] heading;
    logic [1:0] side;
    logic [7:0] new_value;
    logic       sense_left;
    logic       sense_front;
    logic       sense_right;

    modport source (
        output valid, command, cell_x, cell_y, heading, side, new_value,
               sense_left, sense_front, sense_right,
        input  ready
    );
    modport sink (
        input  valid, command, cell_x, cell_y, heading, side, new_value,
               sense_left, sense_front, sense_right,
        output ready
    );
endinterface

interface mwvm_rsp_if;
    logic       valid;
    logic       ready;
    logic       wall_present;
    logic [7:0] cell_value;

    modport source (
        output valid, wall_present, cell_value,
        input  ready
    );
    modport sink (
        input  valid, wall_present, cell_value,
        output ready
    );
endinterface

`default_nettype wire

### src/mwvm_ram.sv
`default_nettype none

module mwvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/mwvm_front.sv
`default_nettype none

module mwvm_front #(
    parameter int MAZE_SIDE = mwvm_pkg::MAZE_SIDE_DEF,
    parameter int INF_VALUE = mwvm_pkg::INF_VALUE_DEF
) (
    mwvm_req_if.sink         i_req,
    input  mwvm_pkg::t_q_stat i_q_stat,
    input  logic             i_clearing,
    output logic             o_push,
    output mwvm_pkg::t_op    o_op
);
    import mwvm_pkg::*;

    t_op op;

    assign i_req.ready = !i_q_stat.full && !i_clearing;
    assign o_push      = i_req.valid && i_req.ready;
    assign o_op        = op;

    always_comb begin
        logic              on_grid;
        logic              side_ok;
        logic              nb_ok;
        t_dir              h;
        t_dir              dir_side;
        logic signed [6:0] nx;
        logic signed [6:0] ny;

        h        = t_dir'(i_req.heading);
        on_grid  = (32'(i_req.cell_x) < MAZE_SIDE) && (32'(i_req.cell_y) < MAZE_SIDE);
        side_ok  = 1'b1;
        dir_side = h;
        case (i_req.side)
            SIDE_FRONT: dir_side = h;
            SIDE_LEFT:  dir_side = t_dir'(2'(i_req.heading + 2'd3));
            SIDE_RIGHT: dir_side = t_dir'(2'(i_req.heading + 2'd1));
            default:    side_ok  = 1'b0;
        endcase

        nx = $signed({3'b000, i_req.cell_x});
        ny = $signed({3'b000, i_req.cell_y});
        unique case (h)
            DIR_N: ny = ny + 7'sd1;
            DIR_E: nx = nx + 7'sd1;
            DIR_S: ny = ny - 7'sd1;
            DIR_W: nx = nx - 7'sd1;
        endcase
        nb_ok = (nx >= 0) && (ny >= 0) && (nx < MAZE_SIDE) && (ny < MAZE_SIDE);

        op          = '0;
        op.kind     = K_CONST;
        op.x        = {1'b0, i_req.cell_x};
        op.y        = {1'b0, i_req.cell_y};
        op.dir      = {h, h, h};
        op.wall_val = 1'b0;
        op.data     = '0;

        unique case (t_cmd'(i_req.command)) inside
            CMD_REINIT: begin
                op.kind = K_INIT;
            end
            CMD_SET_WALL, CMD_DEL_WALL: begin
                if (on_grid && side_ok) begin
                    op.kind     = K_WALL_WR;
                    op.mask     = 3'b001;
                    op.dir[0]   = dir_side;
                    op.wall_val = (t_cmd'(i_req.command) == CMD_SET_WALL);
                end
            end
            CMD_QUERY: begin
                if (on_grid && side_ok) begin
                    op.kind   = K_WALL_RD;
                    op.dir[0] = dir_side;
                end
            end
            CMD_WRITE_VAL: begin
                if (on_grid) begin
                    op.kind = K_VAL_WR;
                    op.data = i_req.new_value;
                end
            end
            CMD_READ_VAL: begin
                if (on_grid) begin
                    op.kind = K_VAL_RD;
                end else begin
                    op.data = 8'(INF_VALUE);
                end
            end
            CMD_NEIGHBOR: begin
                if (nb_ok) begin
                    op.kind = K_VAL_RD;
                    op.x    = nx[4:0];
                    op.y    = ny[4:0];
                end else begin
                    op.data = 8'(INF_VALUE);
                end
            end
            CMD_SENSE: begin
                if (on_grid) begin
                    op.kind     = K_WALL_WR;
                    op.mask     = {i_req.sense_left, i_req.sense_front, i_req.sense_right};
                    op.dir[0]   = t_dir'(2'(i_req.heading + 2'd1));
                    op.dir[1]   = h;
                    op.dir[2]   = t_dir'(2'(i_req.heading + 2'd3));
                    op.wall_val = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### src/mwvm_queue.sv
`default_nettype none

module mwvm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mwvm_pkg::t_op     i_op,
    input  logic              i_pop,
    output logic              o_head_vld,
    output mwvm_pkg::t_op     o_head,
    output mwvm_pkg::t_q_stat o_stat
);
    import mwvm_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    t_op             r_ent [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNTW'(1);
                2'b01:   r_cnt <= r_cnt - CNTW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head       = r_ent[r_rp];
    assign o_head_vld   = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == CNTW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

### src/mwvm_back.sv
`default_nettype none

module mwvm_back #(
    parameter int MAZE_SIDE = mwvm_pkg::MAZE_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_vld,
    input  mwvm_pkg::t_op i_head,
    output logic          o_pop,
    output logic          o_clearing,
    mwvm_rsp_if.source    o_rsp
);
    import mwvm_pkg::*;

    localparam int LAT    = MAZE_SIDE + 1;
    localparam int WDEPTH = LAT * LAT;
    localparam int CELLS  = MAZE_SIDE * MAZE_SIDE;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int CAW    = $clog2(CELLS);
    localparam int CW     = $clog2(LAT);

    t_bk_state          r_state, n_state;
    logic [WAW-1:0]     r_clr, n_clr;
    logic [CW-1:0]      r_cx, n_cx;
    logic [CW-1:0]      r_cy, n_cy;
    t_op                r_op, n_op;
    logic [1:0]         r_slot, n_slot;
    logic               r_rd_wall, n_rd_wall;
    logic               r_rd_west, n_rd_west;
    logic               r_out_valid, n_out_valid;
    logic               r_out_wall, n_out_wall;
    logic [VALUE_W-1:0] r_out_value, n_out_value;

    logic               can_put;
    logic [COORD_W-1:0] sel_x, sel_y, ax, ay;
    t_dir               sel_dir;
    logic [WAW-1:0]     wall_addr;
    logic [CAW-1:0]     cell_addr;

    logic               s_we, w_we, s_wdata, w_wdata, s_re, w_re;
    logic [WAW-1:0]     wall_waddr;
    logic               s_rdata, w_rdata;
    logic               cell_we, cell_re;
    logic [CAW-1:0]     cell_waddr;
    logic [VALUE_W-1:0] cell_wdata, cell_rdata;

    // wall address for the slot in service
    always_comb begin
        if (r_state == BK_WALL) begin
            sel_x   = r_op.x;
            sel_y   = r_op.y;
            sel_dir = r_op.dir[r_slot];
        end else begin
            sel_x   = i_head.x;
            sel_y   = i_head.y;
            sel_dir = i_head.dir[0];
        end
        ax        = sel_x + COORD_W'(sel_dir == DIR_E);
        ay        = sel_y + COORD_W'(sel_dir == DIR_N);
        wall_addr = WAW'(ax) * WAW'(LAT) + WAW'(ay);
        cell_addr = CAW'(i_head.x) * CAW'(MAZE_SIDE) + CAW'(i_head.y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_rd_wall   <= n_rd_wall;
        r_rd_west   <= n_rd_west;
        r_out_wall  <= n_out_wall;
        r_out_value <= n_out_value;
    end

    always_comb begin
        can_put     = !r_out_valid || o_rsp.ready;
        n_state     = r_state;
        n_clr       = r_clr;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_op        = r_op;
        n_slot      = r_slot;
        n_rd_wall   = r_rd_wall;
        n_rd_west   = r_rd_west;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_wall  = r_out_wall;
        n_out_value = r_out_value;
        o_pop       = 1'b0;
        s_we        = 1'b0;
        w_we        = 1'b0;
        s_re        = 1'b0;
        w_re        = 1'b0;
        s_wdata     = r_op.wall_val;
        w_wdata     = r_op.wall_val;
        wall_waddr  = wall_addr;
        cell_we     = 1'b0;
        cell_re     = 1'b0;
        cell_waddr  = cell_addr;
        cell_wdata  = i_head.data;

        unique case (r_state)
            BK_CLEAR: begin
                s_we       = 1'b1;
                w_we       = 1'b1;
                wall_waddr = r_clr;
                s_wdata    = (r_cy == '0) || (r_cy == CW'(MAZE_SIDE));
                w_wdata    = (r_cx == '0) || (r_cx == CW'(MAZE_SIDE));
                cell_we    = (r_clr < WAW'(CELLS));
                cell_waddr = r_clr[CAW-1:0];
                cell_wdata = '0;
                n_clr      = r_clr + WAW'(1);
                if (r_cy == CW'(MAZE_SIDE)) begin
                    n_cy = '0;
                    n_cx = r_cx + CW'(1);
                end else begin
                    n_cy = r_cy + CW'(1);
                end
                if (r_clr == WAW'(WDEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_head_vld) begin
                    unique case (i_head.kind)
                        K_INIT: begin
                            if (can_put) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_wall  = 1'b0;
                                n_out_value = '0;
                                n_clr       = '0;
                                n_cx        = '0;
                                n_cy        = '0;
                                n_state     = BK_CLEAR;
                            end
                        end
                        K_CONST: begin
                            if (can_put) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_wall  = 1'b0;
                                n_out_value = i_head.data;
                            end
                        end
                        K_WALL_WR: begin
                            if (can_put) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_wall  = 1'b0;
                                n_out_value = '0;
                                n_op        = i_head;
                                n_slot      = '0;
                                n_state     = BK_WALL;
                            end
                        end
                        K_VAL_WR: begin
                            if (can_put) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_wall  = 1'b0;
                                n_out_value = '0;
                                cell_we     = 1'b1;
                            end
                        end
                        K_WALL_RD: begin
                            o_pop     = 1'b1;
                            s_re      = !sel_dir[0];
                            w_re      = sel_dir[0];
                            n_rd_wall = 1'b1;
                            n_rd_west = sel_dir[0];
                            n_state   = BK_READ;
                        end
                        K_VAL_RD: begin
                            o_pop     = 1'b1;
                            cell_re   = 1'b1;
                            n_rd_wall = 1'b0;
                            n_state   = BK_READ;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_WALL: begin
                if (r_op.mask[r_slot]) begin
                    s_we = !sel_dir[0];
                    w_we = sel_dir[0];
                end
                if (r_slot == 2'(WALL_SLOTS - 1)) begin
                    n_state = BK_IDLE;
                end else begin
                    n_slot = r_slot + 2'd1;
                end
            end
            BK_READ: begin
                if (can_put) begin
                    n_out_valid = 1'b1;
                    n_out_wall  = r_rd_wall && (r_rd_west ? w_rdata : s_rdata);
                    n_out_value = r_rd_wall ? '0 : cell_rdata;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    mwvm_ram #(.WIDTH(1), .DEPTH(WDEPTH)) u_south (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (wall_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (wall_addr),
        .o_rdata (s_rdata)
    );

    mwvm_ram #(.WIDTH(1), .DEPTH(WDEPTH)) u_west (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (wall_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (wall_addr),
        .o_rdata (w_rdata)
    );

    mwvm_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_cells (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_re    (cell_re),
        .i_raddr (cell_addr),
        .o_rdata (cell_rdata)
    );

    assign o_clearing         = (r_state == BK_CLEAR);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.wall_present = r_out_wall;
    assign o_rsp.cell_value   = r_out_value;

endmodule

`default_nettype wire

### src/maze_wall_and_value_map_unit.sv
// Channel  | Dir | Payload
// i_req    | in  | command, cell_x, cell_y, heading, side, new_value, sense_*
// o_rsp    | out | wall_present, cell_value
//
// Front decodes a request into a 2-entry queue; back executes it on three
// RAMs (south walls, west walls, cell values), each with one write port and one
// registered read port. Reinit issue, no-op and value write are answered from
// idle; wall query and value reads pass through a read state; wall set/delete
// and sensed walls step through three slots, at most one wall bit per cycle.
// Reset and reinit run a clearing sweep over all (MAZE_SIDE+1)^2 wall entries (289
// at default); i_req.ready is low during it. o_rsp stalls hold in the result register.
`default_nettype none
`include "maze_wall_and_value_map_unit_defines.svh"

module maze_wall_and_value_map_unit #(
    parameter int MAZE_SIDE = mwvm_pkg::MAZE_SIDE_DEF,
    parameter int INF_VALUE = mwvm_pkg::INF_VALUE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwvm_req_if.sink   i_req,
    mwvm_rsp_if.source o_rsp
);
    import mwvm_pkg::*;

    logic    w_push;
    t_op     w_push_op;
    logic    w_pop;
    logic    w_head_vld;
    t_op     w_head_op;
    t_q_stat w_q_stat;
    logic    w_clearing;

    mwvm_front #(
        .MAZE_SIDE (MAZE_SIDE),
        .INF_VALUE (INF_VALUE)
    ) u_front (
        .i_req      (i_req),
        .i_q_stat   (w_q_stat),
        .i_clearing (w_clearing),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    mwvm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_op       (w_push_op),
        .i_pop      (w_pop),
        .o_head_vld (w_head_vld),
        .o_head     (w_head_op),
        .o_stat     (w_q_stat)
    );

    mwvm_back #(
        .MAZE_SIDE (MAZE_SIDE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (w_head_vld),
        .i_head     (w_head_op),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_rsp      (o_rsp)
    );

    `MWVM_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_stat.full)
    `MWVM_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_q_stat.empty)
    `MWVM_ASSERT_IMP(a_no_req_clear, i_clk, i_rst_n, w_clearing, !i_req.ready)
    `MWVM_ASSERT_IMP(a_wall_no_value, i_clk, i_rst_n, o_rsp.valid && o_rsp.wall_present, o_rsp.cell_value == '0)
    `MWVM_ASSERT_NXT(a_init_clears, i_clk, i_rst_n, w_pop && (w_head_op.kind == K_INIT), w_clearing)

endmodule

`default_nettype wire
